// ===== hw/rtl/bld_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package bld_pkg;
	localparam int MaxDim = 4;
	localparam int IdxW = 2;
	localparam int AddrW = 3 * IdxW;
	localparam int CoordW = 24;
	localparam int PosW = 17;
	localparam int WtW = 17;
	localparam int AccW = 48;
	localparam logic [PosW-1:0] OneQ16 = 17'h10000;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_DEFORM = 1'b1;

	localparam logic [1:0] REG_SIZE_X = 2'd0;
	localparam logic [1:0] REG_SIZE_Y = 2'd1;
	localparam logic [1:0] REG_SIZE_Z = 2'd2;

	typedef struct packed {
		logic signed [CoordW-1:0] x;
		logic signed [CoordW-1:0] y;
		logic signed [CoordW-1:0] z;
	} point_t;

	// binomial factor for degree n and term a, n below 4
	function automatic logic [1:0] binom(input logic [1:0] n, input logic [1:0] a);
		logic [1:0] r;
		begin
			r = 2'd1;
			if (n == 2'd2 && a == 2'd1) r = 2'd2;
			if (n == 2'd3 && (a == 2'd1 || a == 2'd2)) r = 2'd3;
			binom = r;
		end
	endfunction

	// effective size minus one
	function automatic logic [1:0] eff_deg(input logic [2:0] s);
		logic [1:0] r;
		begin
			if (s == 3'd0) r = 2'd0;
			else if (s > 3'd4) r = 2'd3;
			else r = 2'(s - 3'd1);
			eff_deg = r;
		end
	endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/bld_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module bld_ram (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [bld_pkg::AddrW-1:0] waddr,
	input  wire bld_pkg::point_t           wdata,
	input  wire logic [bld_pkg::AddrW-1:0] raddr,
	output bld_pkg::point_t                rdata
);
	bld_pkg::point_t mem [2**bld_pkg::AddrW];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== hw/rtl/bld_weight.sv =====
`timescale 1ns / 1ps
`default_nettype none
// sequential bernstein weight: one multiply per cycle
module bld_weight (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [bld_pkg::PosW-1:0]  t,
	input  wire logic [1:0]                a,
	input  wire logic [1:0]                n,
	output logic                           done,
	output logic [bld_pkg::WtW-1:0]        w
);
	logic [1:0] step_q, a_q, n_q;
	logic [1:0] cnt_q;
	logic busy_q;
	logic [bld_pkg::PosW-1:0] t_q, s_q;
	logic [bld_pkg::WtW-1:0] p_q;
	logic [bld_pkg::PosW-1:0] f;
	logic [33:0] prod;
	logic [18:0] wfull;

	assign f = (step_q < a_q) ? t_q : s_q;
	assign prod = 34'(p_q) * 34'(f) + 34'd32768;
	assign wfull = 19'(p_q) * 19'(bld_pkg::binom(n_q, a_q));
	assign w = (wfull > 19'(bld_pkg::OneQ16)) ? bld_pkg::OneQ16 : wfull[16:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			step_q <= '0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= (n != 2'd0);
				done <= (n == 2'd0);
				step_q <= '0;
				cnt_q <= n;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				cnt_q <= cnt_q - 2'd1;
				if (cnt_q == 2'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			t_q <= t;
			s_q <= bld_pkg::OneQ16 - t;
			a_q <= a;
			n_q <= n;
			p_q <= bld_pkg::OneQ16;
		end else if (busy_q) begin
			p_q <= prod[32:16];
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/bezier_lattice_deform_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Trivariate Bezier lattice deformation.
// Input channel (valid/stall): opcode 0 writes a control point at
// (lattice_i, lattice_j, lattice_k); opcode 1 deforms the rest position
// (rest_u, rest_v, rest_w) and returns one result on the output channel.
// Config channel (valid/ready): cfg_index 0..2 selects size_x/y/z, index 3
// is ignored. It is always ready; write only while the block is idle.
// Writes can follow back to back. A deform first builds the per-axis
// Bernstein weights with one shared weight unit, n+1 weights of degree n
// per axis (n is the effective size minus one), then walks the active
// lattice one control point per cycle from the lattice memory, then
// drains the pipeline. out_valid rises when the drain ends; the next
// input transaction is taken only after the result is accepted, so
// deforms do not overlap; their pace is set by the weight unit, the
// lattice walk and out_stall.
// The result sits in an output register; while out_stall is high it holds
// and no new transaction is taken. Reset clears sizes to 4 and all control;
// the lattice memory is not cleared and must be written before it is used.
module bezier_lattice_deform_top (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               opcode,
	input  wire logic [1:0]         lattice_i,
	input  wire logic [1:0]         lattice_j,
	input  wire logic [1:0]         lattice_k,
	input  wire logic signed [23:0] ctrl_x,
	input  wire logic signed [23:0] ctrl_y,
	input  wire logic signed [23:0] ctrl_z,
	input  wire logic [16:0]        rest_u,
	input  wire logic [16:0]        rest_v,
	input  wire logic [16:0]        rest_w,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [2:0]         cfg_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [23:0]      out_x,
	output logic signed [23:0]      out_y,
	output logic signed [23:0]      out_z,
	output logic                    saturated
);
	typedef enum logic [2:0] {ST_IDLE, ST_WSTART, ST_WWAIT, ST_SUM, ST_DRAIN, ST_OUT} state_t;
	state_t state_q;

	logic [2:0] size_x_q, size_y_q, size_z_q;
	logic [1:0] nx_q, ny_q, nz_q;
	logic [16:0] t_q [3];
	logic [16:0] wt_q [3][4];
	logic [1:0] wax_q, wa_q;
	logic [1:0] ai_q, bi_q, ci_q;
	logic [2:0] drain_q;
	logic [16:0] tc;

	// weight unit
	logic w_start, w_done;
	logic [16:0] w_res;

	// lattice memory
	logic ram_we;
	logic [5:0] raddr;
	bld_pkg::point_t wdata, rdata;

	// pipeline
	logic v_s1, v_s2, v_s3;
	logic [16:0] wx_s1, wy_s1, wz_s1, wz_s2;
	logic [16:0] wxy_s2, w_s3;
	logic [33:0] pxy, pw;
	logic signed [47:0] acc_q [3];
	bld_pkg::point_t pt_s2, pt_s3;

	// rounded and saturated sums
	logic signed [23:0] ox, oy, oz;
	logic sx, sy, sz;

	// flag in the top bit, saturated coordinate below
	function automatic logic [24:0] sat24(input logic signed [47:0] a);
		logic signed [47:0] x;
		logic signed [47:0] r;
		logic s;
		begin
			x = a + 48'sd32768;
			r = x >>> 16;
			s = 1'b0;
			if (r > 48'sd8388607) begin r = 48'sd8388607; s = 1'b1; end
			if (r < -48'sd8388608) begin r = -48'sd8388608; s = 1'b1; end
			sat24 = {s, r[23:0]};
		end
	endfunction

	assign cfg_ready = 1'b1;
	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		tc = t_q[wax_q];
		{sx, ox} = sat24(acc_q[0]);
		{sy, oy} = sat24(acc_q[1]);
		{sz, oz} = sat24(acc_q[2]);
	end

	bld_weight u_weight (
		.clk(clk), .arst_n(arst_n), .start(w_start), .t(tc), .a(wa_q),
		.n(wax_q == 2'd0 ? nx_q : (wax_q == 2'd1 ? ny_q : nz_q)),
		.done(w_done), .w(w_res)
	);

	assign ram_we = in_valid && !in_stall && opcode == bld_pkg::OP_WRITE;
	assign wdata = '{x: ctrl_x, y: ctrl_y, z: ctrl_z};
	assign raddr = {ai_q, bi_q, ci_q};
	assign w_start = (state_q == ST_WSTART);

	bld_ram u_ram (
		.clk(clk), .we(ram_we), .waddr({lattice_i, lattice_j, lattice_k}),
		.wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign pxy = 34'(wx_s1) * 34'(wy_s1) + 34'd32768;
	assign pw = 34'(wxy_s2) * 34'(wz_s2) + 34'd32768;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= 3'd4;
			size_y_q <= 3'd4;
			size_z_q <= 3'd4;
			state_q <= ST_IDLE;
			out_valid <= 1'b0;
			out_x <= '0;
			out_y <= '0;
			out_z <= '0;
			saturated <= 1'b0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			wax_q <= '0;
			wa_q <= '0;
			ai_q <= '0;
			bi_q <= '0;
			ci_q <= '0;
			drain_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					bld_pkg::REG_SIZE_X: size_x_q <= cfg_data;
					bld_pkg::REG_SIZE_Y: size_y_q <= cfg_data;
					bld_pkg::REG_SIZE_Z: size_z_q <= cfg_data;
					default: ;
				endcase
			end
			v_s1 <= (state_q == ST_SUM);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			case (state_q)
				ST_IDLE: begin
					if (in_valid && opcode == bld_pkg::OP_DEFORM) begin
						state_q <= ST_WSTART;
						wax_q <= '0;
						wa_q <= '0;
					end
				end
				ST_WSTART: state_q <= ST_WWAIT;
				ST_WWAIT: begin
					if (w_done) begin
						state_q <= ST_WSTART;
						if (wa_q == (wax_q == 2'd0 ? nx_q : (wax_q == 2'd1 ? ny_q : nz_q))) begin
							wa_q <= '0;
							if (wax_q == 2'd2) begin
								state_q <= ST_SUM;
								ai_q <= '0;
								bi_q <= '0;
								ci_q <= '0;
							end else begin
								wax_q <= wax_q + 2'd1;
							end
						end else begin
							wa_q <= wa_q + 2'd1;
						end
					end
				end
				ST_SUM: begin
					if (ci_q == nz_q) begin
						ci_q <= '0;
						if (bi_q == ny_q) begin
							bi_q <= '0;
							if (ai_q == nx_q) begin
								state_q <= ST_DRAIN;
								drain_q <= 3'd4;
							end else ai_q <= ai_q + 2'd1;
						end else bi_q <= bi_q + 2'd1;
					end else ci_q <= ci_q + 2'd1;
				end
				ST_DRAIN: begin
					drain_q <= drain_q - 3'd1;
					if (drain_q == 3'd0) begin
						state_q <= ST_OUT;
						out_valid <= 1'b1;
						out_x <= ox;
						out_y <= oy;
						out_z <= oz;
						saturated <= sx | sy | sz;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE) begin
			t_q[0] <= (rest_u > bld_pkg::OneQ16) ? bld_pkg::OneQ16 : rest_u;
			t_q[1] <= (rest_v > bld_pkg::OneQ16) ? bld_pkg::OneQ16 : rest_v;
			t_q[2] <= (rest_w > bld_pkg::OneQ16) ? bld_pkg::OneQ16 : rest_w;
			nx_q <= bld_pkg::eff_deg(size_x_q);
			ny_q <= bld_pkg::eff_deg(size_y_q);
			nz_q <= bld_pkg::eff_deg(size_z_q);
			acc_q[0] <= '0;
			acc_q[1] <= '0;
			acc_q[2] <= '0;
		end
		if (state_q == ST_WWAIT && w_done) wt_q[wax_q][wa_q] <= w_res;
		// s1: weights, memory read in flight
		wx_s1 <= wt_q[0][ai_q];
		wy_s1 <= wt_q[1][bi_q];
		wz_s1 <= wt_q[2][ci_q];
		// s2: xy product
		wxy_s2 <= pxy[32:16];
		wz_s2 <= wz_s1;
		// s3: full weight; hold point aligned
		w_s3 <= pw[32:16];
		if (v_s3) begin
			acc_q[0] <= acc_q[0] + 48'($signed({1'b0, w_s3})) * 48'(pt_s3.x);
			acc_q[1] <= acc_q[1] + 48'($signed({1'b0, w_s3})) * 48'(pt_s3.y);
			acc_q[2] <= acc_q[2] + 48'($signed({1'b0, w_s3})) * 48'(pt_s3.z);
		end
	end

	always_ff @(posedge clk) begin
		pt_s2 <= rdata;
		pt_s3 <= pt_s2;
	end
endmodule
`default_nettype wire
